// ===== rtl/aga_pkg.sv =====
// Package for the affine-gap global aligner: score types, link struct between
// cells, command/op/state codes and the shared scoring functions.
// No dependencies.
package aga_pkg;

	localparam int MAX_LEN_DEF = 31;
	localparam int SCORE_W = 18;
	localparam int ROW_W = 5;

	typedef logic signed [SCORE_W-1:0] score_t;
	localparam score_t NEG_SENTINEL = -18'sd99999;

	typedef struct packed {
		score_t m;
		score_t x;
		score_t y;
	} trio_t;

	typedef struct packed {
		logic [3:0]        match;
		logic signed [4:0] ts;
		logic signed [4:0] tv;
		logic signed [4:0] go;
		logic signed [4:0] ge;
	} cfg_t;

	// one row token moving right along the chain
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [1:0]       a;
		trio_t            cur;
		trio_t            diag;
	} link_t;

	typedef struct packed {
		score_t     score;
		logic [1:0] ptr;
	} pick_t;

	localparam logic [1:0] CMD_LOAD_FIRST = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] ST_M = 2'd0;
	localparam logic [1:0] ST_X = 2'd1;
	localparam logic [1:0] ST_Y = 2'd2;
	localparam logic [1:0] PTR_NONE = 2'd3;

	localparam logic [1:0] OP_BOTH = 2'd0;
	localparam logic [1:0] OP_FIRST_GAP = 2'd1;
	localparam logic [1:0] OP_GAP_SECOND = 2'd2;

	localparam logic KIND_SCORE = 1'b0;
	localparam logic KIND_COLUMN = 1'b1;

	localparam logic [2:0] CFG_MATCH = 3'd0;
	localparam logic [2:0] CFG_TRANSITION = 3'd1;
	localparam logic [2:0] CFG_TRANSVERSION = 3'd2;
	localparam logic [2:0] CFG_GAP_OPEN = 3'd3;
	localparam logic [2:0] CFG_GAP_EXTEND = 3'd4;

	// max of three, ties keep the earlier one
	function automatic pick_t best3(score_t a, score_t b, score_t c);
		pick_t r;
		r.score = a;
		r.ptr = ST_M;
		if (b > r.score) begin
			r.score = b;
			r.ptr = ST_X;
		end
		if (c > r.score) begin
			r.score = c;
			r.ptr = ST_Y;
		end
		return r;
	endfunction

	// substitution score; same upper bit means transition
	function automatic score_t subst(logic [1:0] a, logic [1:0] b, cfg_t c);
		score_t s;
		if (a == b) s = score_t'({1'b0, c.match});
		else if (a[1] == b[1]) s = score_t'(c.ts);
		else s = score_t'(c.tv);
		return s;
	endfunction

endpackage

// ===== rtl/aga_cmd_if.sv =====
// Command channel of the aligner: valid/ready plus load/start payload.
// No dependencies.
interface aga_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [4:0] position;
	logic [1:0] base;
	logic [4:0] first_length;
	logic [4:0] second_length;

	modport source (output valid, command, position, base, first_length, second_length,
		input ready);
	modport sink (input valid, command, position, base, first_length, second_length,
		output ready);
endinterface

// ===== rtl/aga_res_if.sv =====
// Result channel of the aligner: valid/ready plus score or column payload.
// No dependencies.
interface aga_res_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic signed [10:0] score;
	logic [1:0]        end_state;
	logic [1:0]        column_op;
	logic [1:0]        first_base;
	logic [1:0]        second_base;
	logic              last;

	modport source (output valid, kind, score, end_state, column_op, first_base,
		second_base, last, input ready);
	modport sink (input valid, kind, score, end_state, column_op, first_base,
		second_base, last, output ready);
endinterface

// ===== rtl/aga_cell.sv =====
// One column cell of the score array: holds the column's three scores and its
// back-pointer column memory. Depends on aga_pkg.
module aga_cell #(
	parameter int MAX_LEN = aga_pkg::MAX_LEN_DEF,
	parameter bit EDGE = 1'b0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  aga_pkg::cfg_t            cfg,
	input  logic [1:0]               b,
	input  aga_pkg::link_t           li,
	output aga_pkg::link_t           lo,
	input  logic [aga_pkg::ROW_W-1:0] rd_row,
	output logic [5:0]               rd_ptr
);
	import aga_pkg::*;

	localparam int RW = $clog2(MAX_LEN + 1);

	logic              valid_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        a_q;
	trio_t             score_q;
	trio_t             diag_q;
	trio_t             nxt;
	logic [1:0]        pm, px, py;
	logic [5:0]        ptr_mem [0:MAX_LEN];
	logic [5:0]        rd_ptr_q;

	// cell update for the incoming row
	always_comb begin
		score_t s, go, ge;
		pick_t rm, rx, ry;
		s = subst(li.a, b, cfg);
		go = score_t'(cfg.go);
		ge = score_t'(cfg.ge);
		rm = best3(li.diag.m + s, li.diag.x + s, li.diag.y + s);
		rx = best3(score_q.m + go, score_q.x + ge, score_q.y + go);
		ry = best3(li.cur.m + go, li.cur.x + go, li.cur.y + ge);
		nxt = '{m: rm.score, x: rx.score, y: ry.score};
		pm = rm.ptr;
		px = rx.ptr;
		py = ry.ptr;
		if (li.row == '0) begin
			if (EDGE) begin
				nxt = '{m: '0, x: '0, y: '0};
				py = PTR_NONE;
			end else begin
				nxt.m = NEG_SENTINEL;
				nxt.x = NEG_SENTINEL;
				pm = PTR_NONE;
			end
			px = PTR_NONE;
			if (EDGE) pm = PTR_NONE;
		end else if (EDGE) begin
			nxt.m = NEG_SENTINEL;
			nxt.y = NEG_SENTINEL;
			pm = PTR_NONE;
			py = PTR_NONE;
		end
	end

	// token register toward the right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= li.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (li.valid) begin
			score_q <= nxt;
			diag_q <= score_q;
			row_q <= li.row;
			a_q <= li.a;
			ptr_mem[li.row[RW-1:0]] <= {py, px, pm};
		end
		rd_ptr_q <= ptr_mem[rd_row[RW-1:0]];
	end

	assign lo = '{valid: valid_q, row: row_q, a: a_q, cur: score_q, diag: diag_q};
	assign rd_ptr = rd_ptr_q;

endmodule

// ===== rtl/affine_gap_global_aligner.sv =====
// Affine-gap global aligner. Load commands are taken one per cycle while the
// block is idle. A start occupies the block for the matrix fill, set by the row
// wavefront through the chain of MAX_LEN + 1 column cells, then the traceback
// steps (registered pointer read in the cells), then the emitted alignment
// columns (registered trace stack read), plus any output stall. Depends on
// aga_pkg, aga_cmd_if, aga_res_if, aga_cell.
module affine_gap_global_aligner #(
	parameter int MAX_LEN = aga_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	aga_cmd_if.sink     cmd,
	aga_res_if.source   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import aga_pkg::*;

	localparam int RW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SD = 2 * MAX_LEN;
	localparam int SW = $clog2(SD);
	localparam int CW = $clog2(SD + 1);
	localparam int FW = $clog2(2 * MAX_LEN + 4);

	typedef enum logic [2:0] {
		S_IDLE, S_FILL, S_BEST, S_TB_RD, S_TB_USE, S_SCORE, S_POP_RD, S_POP_USE
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	logic [1:0]        first_q [0:MAX_LEN-1];
	logic [1:0]        second_q [0:MAX_LEN-1];
	logic [1:0]        stack_q [0:SD-1];
	logic [1:0]        stack_rd_q;
	link_t             links [0:MAX_LEN+1];
	logic [5:0]        cell_ptr [0:MAX_LEN];
	logic [RW-1:0]     n1_q, n2_q, i_q, j_q;
	logic [FW-1:0]     fill_q;
	logic [CW-1:0]     cnt_q, k_q;
	logic [1:0]        tb_q;
	logic              feed_valid_s1;
	logic [ROW_W-1:0]  feed_row_s1;
	logic [1:0]        feed_a_s1;
	logic              acc, out_free, push, emit;
	logic [AW-1:0]     fb_addr;
	logic [1:0]        fb;
	logic [5:0]        ptr_sel;
	logic [1:0]        nxt_st;
	logic [RW:0]       best_col;
	pick_t             best;
	logic [SW-1:0]     pop_addr;

	logic              rv_q, rkind_q, rlast_q;
	logic signed [10:0] rscore_q;
	logic [1:0]        rstate_q, rop_q, rfb_q, rsb_q;

	assign acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign out_free = !rv_q || res.ready;
	assign emit = out_free && (state_q == S_SCORE || state_q == S_POP_USE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{match: 4'd2, ts: -5'sd1, tv: -5'sd1, go: -5'sd2, ge: -5'sd1};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATCH:        cfg_q.match <= cfg_data[3:0];
				CFG_TRANSITION:   cfg_q.ts <= cfg_data;
				CFG_TRANSVERSION: cfg_q.tv <= cfg_data;
				CFG_GAP_OPEN:     cfg_q.go <= cfg_data;
				CFG_GAP_EXTEND:   cfg_q.ge <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequence stores
	always_ff @(posedge clk) begin
		if (acc && cmd.position < 5'(MAX_LEN)) begin
			if (cmd.command == CMD_LOAD_FIRST) first_q[cmd.position[AW-1:0]] <= cmd.base;
			if (cmd.command == CMD_LOAD_SECOND) second_q[cmd.position[AW-1:0]] <= cmd.base;
		end
	end

	assign fb_addr = (state_q == S_FILL) ? AW'(fill_q - 1'b1) : AW'(i_q);
	assign fb = first_q[fb_addr];

	// cell chain
	assign links[0] = '{valid: feed_valid_s1, row: feed_row_s1, a: feed_a_s1,
		cur: '0, diag: '0};

	for (genvar g = 0; g <= MAX_LEN; g++) begin : g_cell
		logic [1:0] bcol;
		if (g == 0) begin : g_edge
			assign bcol = 2'd0;
		end else begin : g_inner
			assign bcol = second_q[g-1];
		end
		aga_cell #(.MAX_LEN(MAX_LEN), .EDGE(g == 0)) u_cell (
			.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .b(bcol),
			.li(links[g]), .lo(links[g+1]),
			.rd_row(ROW_W'(i_q)), .rd_ptr(cell_ptr[g])
		);
	end

	// final row leaves the cell of column n2 on link n2 + 1
	assign best_col = {1'b0, n2_q} + 1'b1;
	assign best = best3(links[best_col].cur.m, links[best_col].cur.x,
		links[best_col].cur.y);
	assign ptr_sel = cell_ptr[j_q];

	always_comb begin
		case (tb_q)
			ST_M:    nxt_st = ptr_sel[1:0];
			ST_X:    nxt_st = ptr_sel[3:2];
			default: nxt_st = ptr_sel[5:4];
		endcase
	end

	always_comb begin
		case (tb_q)
			ST_M:    push = (i_q != '0) && (j_q != '0);
			ST_X:    push = (i_q != '0);
			default: push = (j_q != '0);
		endcase
		push = push && (state_q == S_TB_USE);
	end

	// trace stack
	assign pop_addr = SW'(cnt_q - k_q - 1'b1);
	always_ff @(posedge clk) begin
		if (push) stack_q[cnt_q[SW-1:0]] <= tb_q;
		stack_rd_q <= stack_q[pop_addr];
	end

	// control: fill, traceback, emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			feed_valid_s1 <= 1'b0;
			rv_q <= 1'b0;
			n1_q <= '0;
			n2_q <= '0;
			i_q <= '0;
			j_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			tb_q <= ST_M;
			feed_row_s1 <= '0;
			feed_a_s1 <= '0;
			rkind_q <= KIND_SCORE;
			rscore_q <= '0;
			rstate_q <= '0;
			rop_q <= OP_BOTH;
			rfb_q <= '0;
			rsb_q <= '0;
			rlast_q <= 1'b0;
		end else begin
			rv_q <= emit || (rv_q && !res.ready);
			feed_valid_s1 <= (state_q == S_FILL) && (fill_q <= FW'(n1_q));
			case (state_q)
				S_IDLE: begin
					if (acc && cmd.command == CMD_START) begin
						n1_q <= (cmd.first_length > 5'(MAX_LEN)) ? RW'(MAX_LEN)
							: RW'(cmd.first_length);
						n2_q <= (cmd.second_length > 5'(MAX_LEN)) ? RW'(MAX_LEN)
							: RW'(cmd.second_length);
						fill_q <= '0;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_q <= FW'(n1_q)) begin
						feed_row_s1 <= ROW_W'(fill_q);
						feed_a_s1 <= (fill_q == '0) ? 2'd0 : fb;
					end
					fill_q <= fill_q + 1'b1;
					if (fill_q == FW'(n1_q) + FW'(MAX_LEN + 2)) state_q <= S_BEST;
				end
				S_BEST: begin
					tb_q <= best.ptr;
					i_q <= n1_q;
					j_q <= n2_q;
					cnt_q <= '0;
					state_q <= S_TB_RD;
				end
				S_TB_RD: begin
					if ((i_q == '0 && j_q == '0) || cnt_q == CW'(SD) || tb_q == PTR_NONE)
						state_q <= S_SCORE;
					else
						state_q <= S_TB_USE;
				end
				S_TB_USE: begin
					if (push) begin
						if (tb_q != ST_Y) i_q <= i_q - 1'b1;
						if (tb_q != ST_X) j_q <= j_q - 1'b1;
						cnt_q <= cnt_q + 1'b1;
						tb_q <= nxt_st;
						state_q <= S_TB_RD;
					end else begin
						state_q <= S_SCORE;
					end
				end
				// chain holds the final row until the next start
				S_SCORE: begin
					if (out_free) begin
						rkind_q <= KIND_SCORE;
						rscore_q <= best.score[10:0];
						rstate_q <= best.ptr;
						rop_q <= OP_BOTH;
						rfb_q <= '0;
						rsb_q <= '0;
						rlast_q <= (cnt_q == '0);
						k_q <= '0;
						state_q <= (cnt_q == '0) ? S_IDLE : S_POP_RD;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_USE;
				end
				S_POP_USE: begin
					if (out_free) begin
						rkind_q <= KIND_COLUMN;
						rscore_q <= '0;
						rstate_q <= '0;
						rfb_q <= (stack_rd_q == ST_Y) ? 2'd0 : fb;
						rsb_q <= (stack_rd_q == ST_X) ? 2'd0 : second_q[AW'(j_q)];
						case (stack_rd_q)
							ST_M:    rop_q <= OP_BOTH;
							ST_X:    rop_q <= OP_FIRST_GAP;
							default: rop_q <= OP_GAP_SECOND;
						endcase
						if (stack_rd_q != ST_Y) i_q <= i_q + 1'b1;
						if (stack_rd_q != ST_X) j_q <= j_q + 1'b1;
						rlast_q <= (k_q + 1'b1 == cnt_q);
						k_q <= k_q + 1'b1;
						state_q <= (k_q + 1'b1 == cnt_q) ? S_IDLE : S_POP_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = rv_q;
	assign res.kind = rkind_q;
	assign res.score = rscore_q;
	assign res.end_state = rstate_q;
	assign res.column_op = rop_q;
	assign res.first_base = rfb_q;
	assign res.second_base = rsb_q;
	assign res.last = rlast_q;

endmodule

// ===== verif/aga_checker.sv =====
// Checker for the affine-gap global aligner: watches the command, result and
// register ports, predicts the score and alignment columns, and compares them.
// Depends on aga_pkg, aga_cmd_if, aga_res_if.
module aga_checker
	import aga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	aga_cmd_if         cmd,
	aga_res_if         res,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_MAX = MAX_LEN_DEF;
	localparam int SENTINEL = -99999;

	typedef struct {
		logic               kind;
		logic signed [10:0] score;
		logic [1:0]         end_state;
		logic [1:0]         column_op;
		logic [1:0]         first_base;
		logic [1:0]         second_base;
		logic               last;
	} column_t;

	column_t    alignment_q[$];
	logic [1:0] first_seq[SEQ_MAX];
	logic [1:0] second_seq[SEQ_MAX];
	logic [5:0] ptr_grid[0:SEQ_MAX][0:SEQ_MAX];
	cfg_t       scoring;

	// one line per mismatch
	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int pair_score(logic [1:0] a, logic [1:0] b);
		if (a == b) return int'(scoring.match);
		if (a[1] == b[1]) return int'(scoring.ts);
		return int'(scoring.tv);
	endfunction

	// max of three, ties keep the earlier state
	function automatic int max3(int a, int b, int c, output logic [1:0] which);
		int m;
		m = a;
		which = ST_M;
		if (b > m) begin
			m = b;
			which = ST_X;
		end
		if (c > m) begin
			m = c;
			which = ST_Y;
		end
		return m;
	endfunction

	// matrix fill, traceback, then columns in forward order
	task automatic predict_alignment(int n1, int n2);
		int prev[0:SEQ_MAX][0:2];
		int cur[0:SEQ_MAX][0:2];
		int go, ge, s, best, i, j, cnt;
		logic [1:0] pm, px, py, state, nxt, top_state;
		logic [1:0] path[2*SEQ_MAX];
		column_t col;
		go = int'(scoring.go);
		ge = int'(scoring.ge);
		for (int r = 0; r <= n1; r++) begin
			for (int c = 0; c <= n2; c++) begin
				if (r == 0 && c == 0) begin
					cur[c] = '{0, 0, 0};
					pm = PTR_NONE; px = PTR_NONE; py = PTR_NONE;
				end else begin
					if (r == 0 || c == 0) begin
						cur[c][0] = SENTINEL;
						pm = PTR_NONE;
					end else begin
						s = pair_score(first_seq[r-1], second_seq[c-1]);
						cur[c][0] = max3(prev[c-1][0] + s, prev[c-1][1] + s,
							prev[c-1][2] + s, pm);
					end
					if (r == 0) begin
						cur[c][1] = SENTINEL;
						px = PTR_NONE;
					end else
						cur[c][1] = max3(prev[c][0] + go, prev[c][1] + ge, prev[c][2] + go, px);
					if (c == 0) begin
						cur[c][2] = SENTINEL;
						py = PTR_NONE;
					end else
						cur[c][2] = max3(cur[c-1][0] + go, cur[c-1][1] + go,
							cur[c-1][2] + ge, py);
				end
				ptr_grid[r][c] = {py, px, pm};
			end
			prev = cur;
		end
		best = max3(prev[n2][0], prev[n2][1], prev[n2][2], top_state);
		i = n1;
		j = n2;
		cnt = 0;
		state = top_state;
		while ((i > 0 || j > 0) && cnt < 2 * SEQ_MAX) begin
			if (state == PTR_NONE) break;
			nxt = ptr_grid[i][j][2*state +: 2];
			if (state == ST_M) begin
				if (i == 0 || j == 0) break;
				i--; j--;
			end else if (state == ST_X) begin
				if (i == 0) break;
				i--;
			end else begin
				if (j == 0) break;
				j--;
			end
			path[cnt++] = state;
			state = nxt;
		end
		col = '{KIND_SCORE, best[10:0], top_state, OP_BOTH, 2'd0, 2'd0, cnt == 0};
		alignment_q.push_back(col);
		for (int k = 0; k < cnt; k++) begin
			col = '{KIND_COLUMN, 11'sd0, ST_M, OP_BOTH, 2'd0, 2'd0, k == cnt - 1};
			case (path[cnt-1-k])
				ST_M: begin
					col.first_base = first_seq[i];
					col.second_base = second_seq[j];
					i++; j++;
				end
				ST_X: begin
					col.column_op = OP_FIRST_GAP;
					col.first_base = first_seq[i];
					i++;
				end
				default: begin
					col.column_op = OP_GAP_SECOND;
					col.second_base = second_seq[j];
					j++;
				end
			endcase
			alignment_q.push_back(col);
		end
	endtask

	// sample every channel at the clock edge
	always @(posedge clk or negedge arst_n) begin
		column_t want;
		if (!arst_n) begin
			alignment_q.delete();
			scoring <= '{4'd2, -5'sd1, -5'sd1, -5'sd2, -5'sd1};
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MATCH:        scoring.match <= cfg_data[3:0];
					CFG_TRANSITION:   scoring.ts <= cfg_data;
					CFG_TRANSVERSION: scoring.tv <= cfg_data;
					CFG_GAP_OPEN:     scoring.go <= cfg_data;
					CFG_GAP_EXTEND:   scoring.ge <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.command)
					CMD_LOAD_FIRST:  if (cmd.position < SEQ_MAX) first_seq[cmd.position] = cmd.base;
					CMD_LOAD_SECOND: if (cmd.position < SEQ_MAX) second_seq[cmd.position] = cmd.base;
					CMD_START:       predict_alignment(int'(cmd.first_length),
						int'(cmd.second_length));
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (alignment_q.size() == 0)
					report_mismatch("unexpected transfer", 1, 0);
				else begin
					want = alignment_q.pop_front();
					if (res.kind !== want.kind) report_mismatch("kind", res.kind, want.kind);
					if (res.score !== want.score) report_mismatch("score", res.score, want.score);
					if (res.end_state !== want.end_state)
						report_mismatch("end_state", res.end_state, want.end_state);
					if (res.column_op !== want.column_op)
						report_mismatch("column_op", res.column_op, want.column_op);
					if (res.first_base !== want.first_base)
						report_mismatch("first_base", res.first_base, want.first_base);
					if (res.second_base !== want.second_base)
						report_mismatch("second_base", res.second_base, want.second_base);
					if (res.last !== want.last) report_mismatch("last", res.last, want.last);
				end
			end
			pending = alignment_q.size();
		end
	end

endmodule

// ===== verif/tb_affine_gap_global_aligner.sv =====
// Testbench top for the affine-gap global aligner: clock, reset, register
// programming, load/start stimulus with idling phases, watchdog and verdict.
// Depends on aga_pkg, aga_cmd_if, aga_res_if, aga_checker and the aligner.
module tb_affine_gap_global_aligner;
	timeunit 1ns;
	timeprecision 1ps;
	import aga_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [4:0] cfg_data;
	int         errors, pending;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         quiet_cycles = 0;
	logic [30:0] first_loaded = '0;
	logic [30:0] second_loaded = '0;

	aga_cmd_if cmd_ch();
	aga_res_if res_ch();

	affine_gap_global_aligner i_dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	aga_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one command transfer; valid stays up for a back-to-back successor
	task automatic send(logic [1:0] op, logic [4:0] pos, logic [1:0] b,
		logic [4:0] n1, logic [4:0] n2);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.position <= pos;
		cmd_ch.base <= b;
		cmd_ch.first_length <= n1;
		cmd_ch.second_length <= n2;
		do @(posedge clk); while (!cmd_ch.ready);
		if (op == CMD_LOAD_FIRST && pos < 31) first_loaded[pos] = 1'b1;
		if (op == CMD_LOAD_SECOND && pos < 31) second_loaded[pos] = 1'b1;
	endtask

	task automatic load_first(int pos, logic [1:0] b);
		send(CMD_LOAD_FIRST, pos[4:0], b, 5'($urandom), 5'($urandom));
	endtask

	task automatic load_second(int pos, logic [1:0] b);
		send(CMD_LOAD_SECOND, pos[4:0], b, 5'($urandom), 5'($urandom));
	endtask

	task automatic start(int n1, int n2);
		send(CMD_START, 5'($urandom), 2'($urandom), n1[4:0], n2[4:0]);
	endtask

	// length of the loaded prefix of a sequence
	function automatic int loaded_prefix(logic [30:0] mask);
		int n;
		n = 0;
		while (n < 31 && mask[n]) n++;
		return n;
	endfunction

	// let the block go idle before touching the registers
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic program_regs(int m, int ts, int tv, int go, int ge);
		int vals[5];
		vals = '{m, ts, tv, go, ge};
		for (int k = 0; k < 5; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= k[2:0];
			cfg_data <= vals[k][4:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// well-formed load run then start, mostly short, now and then full length
	task automatic random_alignment(output int items);
		int n1, n2;
		n1 = ($urandom_range(9) == 0) ? 31 : $urandom_range(8);
		n2 = ($urandom_range(9) == 0) ? 31 : $urandom_range(8);
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(1)) n1 = 0; else n2 = 0;
		end
		for (int p = 0; p < n1; p++) load_first(p, 2'($urandom));
		for (int p = 0; p < n2; p++) load_second(p, 2'($urandom));
		start(n1, n2);
		items = n1 + n2 + 1;
	endtask

	// noise: ignored commands, stray loads, starts over what is already loaded
	task automatic random_noise();
		case ($urandom_range(3))
			0: send(2'd3, 5'($urandom), 2'($urandom), 5'($urandom), 5'($urandom));
			1: if ($urandom_range(1)) load_first(31, 2'($urandom));
				else load_second(31, 2'($urandom));
			2: if ($urandom_range(1)) load_first($urandom_range(30), 2'($urandom));
				else load_second($urandom_range(30), 2'($urandom));
			default: start($urandom_range(loaded_prefix(first_loaded)),
				$urandom_range(loaded_prefix(second_loaded)));
		endcase
	endtask

	initial begin
		int sent;
		int items;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_LOAD_FIRST;
		cmd_ch.position <= '0;
		cmd_ch.base <= '0;
		cmd_ch.first_length <= '0;
		cmd_ch.second_length <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MATCH;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pair, unused command, ignored load, edges, all bases
		start(0, 0);
		send(2'd3, 5'd31, 2'd3, 5'd31, 5'd31);
		load_first(31, 2'd3);
		for (int p = 0; p < 4; p++) load_first(p, p[1:0]);
		load_second(0, 2'd0);
		load_second(1, 2'd2);
		load_second(2, 2'd1);
		load_second(3, 2'd3);
		start(4, 4);
		start(0, 3);
		start(2, 0);
		start(1, 4);
		start(4, 1);
		drain();

		// phases: reset values, two extremes, random settings, then a fixed setting
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: program_regs(15, 15, 15, 0, 0);
				2: program_regs(0, -15, -15, -15, -15);
				3: program_regs($urandom_range(15), int'($urandom_range(30)) - 15,
					int'($urandom_range(30)) - 15, -int'($urandom_range(15)),
					-int'($urandom_range(15)));
				4: program_regs(2, -1, -3, -2, -1);
				default: ;
			endcase
			idle_pct = (ph == 1) ? 73 : (ph == 3) ? 25 : 0;
			stall_pct = (ph == 2) ? 73 : (ph == 3) ? 25 : 0;
			sent = 0;
			while (sent < 52) begin
				if ($urandom_range(3) == 0) begin
					random_noise();
					sent += 1;
				end else begin
					random_alignment(items);
					sent += items;
				end
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
